// ===== design/ppmp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppmp_pkg
// Shared constants and types for the point projection marker plotter.
// ----------------------------------------------------------------------------
package ppmp_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int SCREEN_BITS = 12;

    localparam int COORD_W = 32;
    localparam int PROD_W  = 2 * COORD_W;
    localparam int DEN_W   = COORD_W + 1;
    // quotient magnitudes of 2^QUOT_W and up can never land on screen
    localparam int QUOT_W  = COORD_W + 1;
    localparam int DIV_LAT = QUOT_W + 3;
    localparam int SUM_W   = QUOT_W + 3;
    localparam int RND_W   = SUM_W - FRAC_BITS;
    localparam int WIN_W   = SCREEN_BITS + 1;
    localparam int IDX_W   = 16;
    localparam int HL_W    = IDX_W + 1;
    localparam int COL_W   = 24;

    localparam logic [COL_W-1:0] COLOUR_HIGHLIGHT = 24'h00FFFF;
    localparam logic [COL_W-1:0] COLOUR_NORMAL    = 24'hFF0000;
    localparam logic [WIN_W-1:0] WIN_CAP          = WIN_W'(1) << SCREEN_BITS;

    typedef enum logic [2:0] {
        REG_EYE   = 3'd0,
        REG_ORTHO = 3'd1,
        REG_CX    = 3'd2,
        REG_CY    = 3'd3,
        REG_W     = 3'd4,
        REG_H     = 3'd5,
        REG_HL    = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic                      hit;
        logic                      final_pt;
        logic                      dz;
    } side_t;

endpackage

// ===== design/ppmp_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppmp_div
// Pipelined signed divider, one quotient bit per stage, truncating toward
// zero. Flags quotients too large for the screen path instead of forming them.
// ----------------------------------------------------------------------------
module ppmp_div
    import ppmp_pkg::*;
(
    input  logic                     clk,
    input  logic                     en,
    input  logic signed [PROD_W-1:0] num,
    input  logic signed [DEN_W-1:0]  den,
    output logic signed [QUOT_W:0]   quot,
    output logic                     ovf
);

    localparam int MAG_W = PROD_W - 1;
    localparam int HI_W  = MAG_W - QUOT_W;

    logic [MAG_W-1:0] mag_reg;
    logic [DEN_W-1:0] dmag_a_reg;
    logic             neg_a_reg;

    logic [DEN_W-1:0]  rem_reg  [0:QUOT_W];
    logic [QUOT_W-1:0] low_reg  [0:QUOT_W];
    logic [QUOT_W-1:0] q_reg    [0:QUOT_W];
    logic [DEN_W-1:0]  dmag_reg [0:QUOT_W];
    logic              neg_reg  [0:QUOT_W];
    logic              ovf_reg  [0:QUOT_W];

    logic signed [QUOT_W:0] quot_reg;
    logic                   ovf_out_reg;

    logic [PROD_W-1:0] num_abs;
    logic [DEN_W-1:0]  den_abs;

    assign num_abs = num[PROD_W-1] ? (PROD_W'(0) - num) : num;
    assign den_abs = den[DEN_W-1] ? (DEN_W'(0) - den) : den;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg    <= num_abs[MAG_W-1:0];
            dmag_a_reg <= den_abs;
            neg_a_reg  <= num[PROD_W-1] ^ den[DEN_W-1];

            rem_reg[0]  <= DEN_W'(mag_reg[MAG_W-1:QUOT_W]);
            low_reg[0]  <= mag_reg[QUOT_W-1:0];
            q_reg[0]    <= '0;
            dmag_reg[0] <= dmag_a_reg;
            neg_reg[0]  <= neg_a_reg;
            ovf_reg[0]  <= DEN_W'(mag_reg[MAG_W-1:QUOT_W]) >= dmag_a_reg;
        end
    end

    // guard against HI_W ever exceeding DEN_W through a package edit
    logic unused_hi;
    assign unused_hi = (HI_W > DEN_W);

    genvar j;
    generate
        for (j = 0; j < QUOT_W; j++)
        begin : g_stage
            logic [DEN_W:0] trial;
            logic           ge;
            assign trial = {rem_reg[j], low_reg[j][QUOT_W-1-j]};
            assign ge    = trial >= {1'b0, dmag_reg[j]};

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[j+1]  <= ge ? DEN_W'(trial - {1'b0, dmag_reg[j]})
                                        : trial[DEN_W-1:0];
                    low_reg[j+1]  <= low_reg[j];
                    q_reg[j+1]    <= {q_reg[j][QUOT_W-2:0], ge};
                    dmag_reg[j+1] <= dmag_reg[j];
                    neg_reg[j+1]  <= neg_reg[j];
                    ovf_reg[j+1]  <= ovf_reg[j];
                end
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quot_reg    <= neg_reg[QUOT_W] ? -$signed({1'b0, q_reg[QUOT_W]})
                                           :  $signed({1'b0, q_reg[QUOT_W]});
            ovf_out_reg <= ovf_reg[QUOT_W] | unused_hi;
        end
    end

    assign quot = quot_reg;
    assign ovf  = ovf_out_reg;

endmodule

// ===== design/point_project_marker_plot_core.sv =====
`timescale 1ns / 1ps
// Flow: one point per cycle enters while not stalled; a visible point holds the
// output for 4 words on the single output channel. Culled points produce nothing
// (final ones one word).
// Reset: asynchronous active low; clears all valid bits, loads register defaults.
// ----------------------------------------------------------------------------
// point_project_marker_plot_core
// Perspective or orthographic projection of one point and emission of a 2x2 pixel marker.
// ----------------------------------------------------------------------------
module point_project_marker_plot_core
    import ppmp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [111:0] s_tdata,   // point_x, point_y, point_z, point_index
    input  logic         s_tlast,   // final_point
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [47:0]  m_tdata,   // pixel_x, pixel_y, pixel_colour
    output logic         m_tlast,   // run_last
    output logic [1:0]   m_tuser,   // pixel_write, frame_done
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    // ---------------- configuration
    logic signed [COORD_W-1:0] eye_reg, cx_reg, cy_reg;
    logic                      ortho_reg;
    logic [WIN_W-1:0]          win_w_reg, win_h_reg;
    logic [HL_W-1:0]           hl_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eye_reg   <= 32'sd65536000;
            ortho_reg <= 1'b0;
            cx_reg    <= 32'sd20971520;
            cy_reg    <= 32'sd15728640;
            win_w_reg <= WIN_W'(640);
            win_h_reg <= WIN_W'(480);
            hl_reg    <= '1;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_EYE:   eye_reg   <= cfg_data;
                REG_ORTHO: ortho_reg <= cfg_data[0];
                REG_CX:    cx_reg    <= cfg_data;
                REG_CY:    cy_reg    <= cfg_data;
                REG_W:     win_w_reg <= cfg_data[WIN_W-1:0];
                REG_H:     win_h_reg <= cfg_data[WIN_W-1:0];
                REG_HL:    hl_reg    <= cfg_data[HL_W-1:0];
                default:   ;
            endcase
        end
    end

    // ---------------- pipeline control
    logic en;
    logic ser_free;
    logic p4_valid_reg, p4_vis_reg, p4_final_reg;

    assign en       = !p4_valid_reg || (!p4_vis_reg && !p4_final_reg) || ser_free;
    assign s_tready = en;

    // ---------------- stage 1: products and denominator
    logic signed [COORD_W-1:0] in_x, in_y, in_z;
    logic [IDX_W-1:0]          in_idx;

    assign in_x   = s_tdata[31:0];
    assign in_y   = s_tdata[63:32];
    assign in_z   = s_tdata[95:64];
    assign in_idx = s_tdata[111:96];

    logic                      s1_valid_reg;
    logic signed [PROD_W-1:0]  s1_px_reg, s1_py_reg;
    logic signed [DEN_W-1:0]   s1_den_reg;
    logic signed [COORD_W-1:0] s1_x_reg, s1_y_reg;
    logic                      s1_hit_reg, s1_final_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (en)
            s1_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_px_reg    <= PROD_W'(in_x) * PROD_W'(eye_reg);
            s1_py_reg    <= PROD_W'(in_y) * PROD_W'(eye_reg);
            s1_den_reg   <= DEN_W'(eye_reg) - DEN_W'(in_z);
            s1_x_reg     <= in_x;
            s1_y_reg     <= in_y;
            s1_hit_reg   <= !hl_reg[HL_W-1] && (hl_reg[IDX_W-1:0] == in_idx);
            s1_final_reg <= s_tlast;
        end
    end

    // ---------------- divider and matching side band
    logic signed [QUOT_W:0] qx, qy;
    logic                   ovfx, ovfy;

    ppmp_div u_div_x (.clk(clk), .en(en), .num(s1_px_reg), .den(s1_den_reg),
                      .quot(qx), .ovf(ovfx));
    ppmp_div u_div_y (.clk(clk), .en(en), .num(s1_py_reg), .den(s1_den_reg),
                      .quot(qy), .ovf(ovfy));

    side_t sb_reg  [0:DIV_LAT-1];
    logic  sbv_reg [0:DIV_LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIV_LAT; i++)
                sbv_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            sbv_reg[0] <= s1_valid_reg;
            for (int i = 1; i < DIV_LAT; i++)
                sbv_reg[i] <= sbv_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sb_reg[0].x        <= s1_x_reg;
            sb_reg[0].y        <= s1_y_reg;
            sb_reg[0].hit      <= s1_hit_reg;
            sb_reg[0].final_pt <= s1_final_reg;
            sb_reg[0].dz       <= (s1_den_reg == '0);
            for (int i = 1; i < DIV_LAT; i++)
                sb_reg[i] <= sb_reg[i-1];
        end
    end

    // ---------------- P1: select and add centre
    side_t                   sbo;
    logic signed [QUOT_W:0]  selx, sely;
    logic                    p1_valid_reg, p1_cull_reg, p1_hit_reg, p1_final_reg;
    logic signed [SUM_W-1:0] p1_sx_reg, p1_sy_reg;

    assign sbo  = sb_reg[DIV_LAT-1];
    assign selx = ortho_reg ? (QUOT_W+1)'(sbo.x) : qx;
    assign sely = ortho_reg ? (QUOT_W+1)'(sbo.y) : qy;

    // P2..P4 registers
    logic                    p2_valid_reg, p2_cull_reg, p2_hit_reg, p2_final_reg;
    logic [SUM_W-1:0]        p2_mx_reg, p2_my_reg;
    logic                    p2_nx_reg, p2_ny_reg;
    logic                    p3_valid_reg, p3_cull_reg, p3_hit_reg, p3_final_reg;
    logic signed [RND_W:0]   p3_px_reg, p3_py_reg;
    logic                    p4_hit_reg;
    logic [SCREEN_BITS-1:0]  p4_px_reg, p4_py_reg;

    logic [SUM_W-1:0]        rx_full, ry_full;
    logic [RND_W-1:0]        rx, ry;
    logic signed [RND_W+1:0] px1, py1;
    logic [WIN_W-1:0]        wl, hl;
    logic                    in_win;

    assign rx_full = p2_mx_reg + (SUM_W'(1) << (FRAC_BITS - 1));
    assign ry_full = p2_my_reg + (SUM_W'(1) << (FRAC_BITS - 1));
    assign rx      = rx_full[SUM_W-1:FRAC_BITS];
    assign ry      = ry_full[SUM_W-1:FRAC_BITS];

    assign wl  = (win_w_reg > WIN_CAP) ? WIN_CAP : win_w_reg;
    assign hl  = (win_h_reg > WIN_CAP) ? WIN_CAP : win_h_reg;
    assign px1 = (RND_W+2)'(p3_px_reg) + (RND_W+2)'(1);
    assign py1 = (RND_W+2)'(p3_py_reg) + (RND_W+2)'(1);
    assign in_win = !p3_px_reg[RND_W] && !p3_py_reg[RND_W]
                 && (px1 < $signed((RND_W+2)'(wl)))
                 && (py1 < $signed((RND_W+2)'(hl)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
            p4_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            p1_valid_reg <= sbv_reg[DIV_LAT-1];
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
            p4_valid_reg <= p3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_sx_reg    <= SUM_W'(selx) + SUM_W'(cx_reg);
            p1_sy_reg    <= SUM_W'(sely) + SUM_W'(cy_reg);
            p1_cull_reg  <= !ortho_reg && (sbo.dz || ovfx || ovfy);
            p1_hit_reg   <= sbo.hit;
            p1_final_reg <= sbo.final_pt;

            p2_nx_reg    <= p1_sx_reg[SUM_W-1];
            p2_ny_reg    <= p1_sy_reg[SUM_W-1];
            p2_mx_reg    <= p1_sx_reg[SUM_W-1] ? SUM_W'(-p1_sx_reg) : p1_sx_reg;
            p2_my_reg    <= p1_sy_reg[SUM_W-1] ? SUM_W'(-p1_sy_reg) : p1_sy_reg;
            p2_cull_reg  <= p1_cull_reg;
            p2_hit_reg   <= p1_hit_reg;
            p2_final_reg <= p1_final_reg;

            p3_px_reg    <= p2_nx_reg ? -$signed({1'b0, rx}) : $signed({1'b0, rx});
            p3_py_reg    <= p2_ny_reg ? -$signed({1'b0, ry}) : $signed({1'b0, ry});
            p3_cull_reg  <= p2_cull_reg;
            p3_hit_reg   <= p2_hit_reg;
            p3_final_reg <= p2_final_reg;

            p4_vis_reg   <= !p3_cull_reg && in_win;
            p4_px_reg    <= p3_px_reg[SCREEN_BITS-1:0];
            p4_py_reg    <= p3_py_reg[SCREEN_BITS-1:0];
            p4_hit_reg   <= p3_hit_reg;
            p4_final_reg <= p3_final_reg;
        end
    end

    // ---------------- output serializer: 4 words per visible marker, one per empty final marker
    logic                   ser_valid_reg, ser_write_reg, ser_final_reg;
    logic [1:0]             ser_k_reg;
    logic [SCREEN_BITS-1:0] ser_x_reg, ser_y_reg;
    logic [COL_W-1:0]       ser_col_reg;
    logic                   ser_last, load;

    assign ser_last = !ser_write_reg || (ser_k_reg == 2'd3);
    assign ser_free = !ser_valid_reg || (m_tready && ser_last);
    assign load     = p4_valid_reg && (p4_vis_reg || p4_final_reg) && ser_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ser_valid_reg <= 1'b0;
            ser_k_reg     <= 2'd0;
        end
        else if (load)
        begin
            ser_valid_reg <= 1'b1;
            ser_k_reg     <= 2'd0;
        end
        else if (ser_valid_reg && m_tready)
        begin
            if (ser_last)
                ser_valid_reg <= 1'b0;
            else
                ser_k_reg <= ser_k_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ser_write_reg <= p4_vis_reg;
            ser_final_reg <= p4_final_reg;
            ser_x_reg     <= p4_vis_reg ? p4_px_reg : '0;
            ser_y_reg     <= p4_vis_reg ? p4_py_reg : '0;
            ser_col_reg   <= !p4_vis_reg ? '0
                           : (p4_hit_reg ? COLOUR_HIGHLIGHT : COLOUR_NORMAL);
        end
    end

    assign m_tvalid = ser_valid_reg;
    assign m_tdata  = {ser_col_reg,
                       ser_y_reg + SCREEN_BITS'(ser_k_reg[1]),
                       ser_x_reg + SCREEN_BITS'(ser_k_reg[0])};
    assign m_tlast  = ser_last;
    assign m_tuser  = {ser_final_reg && ser_last, ser_write_reg};

endmodule

// ===== design/ppmp_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppmp_chk
// Port-level checks on the marker output stream.
// ----------------------------------------------------------------------------
module ppmp_chk
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic        m_tlast,
    input logic [1:0]  m_tuser
);

    // frame end only on the closing word of a point
    a_done_last : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> m_tlast)
        else $error("frame_done without run_last");

    // empty marker is a lone, zeroed, frame-closing word
    a_empty : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tlast && m_tuser[1] && (m_tdata == 48'd0))
        else $error("malformed empty marker");

    // marker words come without gaps
    a_burst : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
        else $error("gap inside marker burst");

    a_hold : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output word changed while stalled");

endmodule

bind point_project_marker_plot_core ppmp_chk u_ppmp_chk
(
    .clk(clk),
    .rst_n(rst_n),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast),
    .m_tuser(m_tuser)
);
